@@ src/ugl_pkg.sv @@
`default_nettype none

package ugl_pkg;

    // Widths of the Q16.16 coordinates, the grid step and the grid position.
    localparam int XY_W   = 32;
    localparam int STEP_W = 31;
    localparam int GRID_W = XY_W + 1;

    // Iteration counter of the bit-serial divider, one dividend bit per cycle.
    localparam int DIV_CNT_W = $clog2(XY_W);

    // Grid spacing after reset: 0.2 in Q16.16.
    localparam logic [STEP_W-1:0] GRID_STEP_RESET = STEP_W'(13107);

    // Largest number of samples that one point may produce.
    localparam int MAX_RUN_DEFAULT = 64;

endpackage

`default_nettype wire

@@ src/ugl_point_if.sv @@
`default_nettype none

interface ugl_point_if;
    logic                             valid;
    logic                             ready;
    logic signed [ugl_pkg::XY_W-1:0]  point_x;
    logic signed [ugl_pkg::XY_W-1:0]  point_y;
    logic                             seq_end;

    modport source (output valid, output point_x, output point_y, output seq_end,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input seq_end,
                  output ready);
endinterface

`default_nettype wire

@@ src/ugl_sample_if.sv @@
`default_nettype none

interface ugl_sample_if;
    logic                             valid;
    logic                             ready;
    logic signed [ugl_pkg::XY_W-1:0]  sample_x;
    logic signed [ugl_pkg::XY_W-1:0]  sample_y;
    logic                             run_last;
    logic                             run_cut;

    modport source (output valid, output sample_x, output sample_y, output run_last,
                    output run_cut, input ready);
    modport sink (input valid, input sample_x, input sample_y, input run_last,
                  input run_cut, output ready);
endinterface

`default_nettype wire

@@ src/uniform_grid_linear_resampler.sv @@
// A first point of a sequence goes through the check and put states to the output register.
// A later point goes through check, load, the bit-serial divider, sum, fin and put for its first sample,
// and from load to put for each further one; a cut run then reruns the divider to skip ahead.
// Throughput: one item at a time; the next item is accepted once the last sample of the
// current one sits in the output register and any skip-ahead is done. Reset is synchronous,
// active low, and returns the grid step to 0.2, clears the segment state and empties the output.
`default_nettype none

module uniform_grid_linear_resampler #(
    parameter int MAX_RUN = ugl_pkg::MAX_RUN_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ugl_pkg::STEP_W-1:0]   i_cfg_data,
    ugl_point_if.sink                    i_point,
    ugl_sample_if.source                 o_sample
);

    localparam int XY_W   = ugl_pkg::XY_W;
    localparam int STEP_W = ugl_pkg::STEP_W;
    localparam int GRID_W = ugl_pkg::GRID_W;
    localparam int DCW    = ugl_pkg::DIV_CNT_W;

    // Run counter holds 0 .. MAX_RUN-1.
    localparam int CW     = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    // MAX_RUN grid steps, the distance that a full run covers.
    localparam int SPAN_W = STEP_W + $clog2(MAX_RUN + 1);
    localparam int CMP_W  = ((SPAN_W > GRID_W) ? SPAN_W : GRID_W) + 2;
    // Divider: partial remainder 2R + num stays below three divisors.
    localparam int SUB_W  = XY_W + 3;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_LOAD    = 4'd2;
    localparam logic [3:0] S_DIV     = 4'd3;
    localparam logic [3:0] S_SUM     = 4'd4;
    localparam logic [3:0] S_FIN     = 4'd5;
    localparam logic [3:0] S_PUT     = 4'd6;
    localparam logic [3:0] S_SKIPLD  = 4'd7;
    localparam logic [3:0] S_SKIPFIN = 4'd8;
    localparam logic [3:0] S_SKIPADD = 4'd9;

    // Control state and the state of the polyline segment.
    logic [3:0]               r_state, n_state;
    logic                     r_out_valid;
    logic                     r_have_first;
    logic signed [XY_W-1:0]   r_prev_x;
    logic signed [XY_W-1:0]   r_prev_y;
    logic signed [GRID_W-1:0] r_ng;
    logic [STEP_W-1:0]        r_grid_step;

    // Datapath registers of the item at work.
    logic signed [XY_W-1:0]   r_x;
    logic signed [XY_W-1:0]   r_y;
    logic                     r_end;
    logic                     r_first;
    logic                     r_cut;
    logic                     r_last;
    logic                     r_neg;
    logic [XY_W-1:0]          r_a;
    logic [CW-1:0]            r_cnt;
    logic [SPAN_W-1:0]        r_span;

    // Bit-serial divider.
    logic                     r_skip;
    logic [XY_W-1:0]          r_sh;
    logic [XY_W-1:0]          r_num;
    logic [XY_W-1:0]          r_dvs;
    logic [XY_W-1:0]          r_rem;
    logic [XY_W-1:0]          r_qa;
    logic [XY_W-1:0]          r_qb;
    logic [DCW-1:0]           r_bit;
    logic [XY_W:0]            r_q;

    // Pending sample and the output register.
    logic signed [XY_W-1:0]   r_sx;
    logic signed [XY_W-1:0]   r_sy;
    logic signed [XY_W-1:0]   r_o_x;
    logic signed [XY_W-1:0]   r_o_y;
    logic                     r_o_last;
    logic                     r_o_cut;

    logic [STEP_W-1:0]        w_step;
    logic                     w_accept;
    logic                     w_out_free;
    logic signed [XY_W:0]     w_dx;
    logic [XY_W:0]            w_dy_pos;
    logic [XY_W:0]            w_dy_neg;
    logic                     w_y_below;
    logic signed [GRID_W:0]   w_xg;
    logic signed [CMP_W-1:0]  w_xg_ext;
    logic signed [CMP_W-1:0]  w_span_ext;
    logic                     w_cut;
    logic                     w_none;
    logic [GRID_W-1:0]        w_gp;
    logic signed [GRID_W:0]   w_ng_step;
    logic signed [GRID_W:0]   w_x_ext;
    logic                     w_past_x;
    logic                     w_div_bit;
    logic [SUB_W-1:0]         w_s;
    logic [SUB_W-1:0]         w_d1;
    logic [SUB_W-1:0]         w_d2;
    logic                     w_ge1;
    logic                     w_ge2;
    logic [SUB_W-1:0]         w_rem_next;
    logic signed [XY_W+1:0]   w_py_ext;
    logic signed [XY_W+1:0]   w_q_ext;
    logic signed [XY_W+1:0]   w_v;
    logic                     w_ovf;
    logic signed [XY_W-1:0]   w_sat;

    // A zero step is treated as the smallest legal step.
    assign w_step     = (r_grid_step == '0) ? STEP_W'(1) : r_grid_step;

    assign w_accept   = i_point.valid && i_point.ready;
    assign w_out_free = !r_out_valid || o_sample.ready;

    assign i_point.ready     = (r_state == S_IDLE);
    assign o_sample.valid    = r_out_valid;
    assign o_sample.sample_x = r_o_x;
    assign o_sample.sample_y = r_o_y;
    assign o_sample.run_last = r_o_last;
    assign o_sample.run_cut  = r_o_cut;

    // Segment geometry. The slope numerator is taken as magnitude and sign so that
    // the divider works on unsigned values and the quotient truncates toward zero.
    assign w_dx      = {r_x[XY_W-1], r_x} - {r_prev_x[XY_W-1], r_prev_x};
    assign w_dy_pos  = {r_y[XY_W-1], r_y} - {r_prev_y[XY_W-1], r_prev_y};
    assign w_dy_neg  = {r_prev_y[XY_W-1], r_prev_y} - {r_y[XY_W-1], r_y};
    assign w_y_below = (r_y < r_prev_y);

    // Distance from the next grid position to the new point. The run is cut when
    // a full run of MAX_RUN steps still does not pass beyond the point.
    assign w_x_ext    = {{2{r_x[XY_W-1]}}, r_x};
    assign w_xg       = w_x_ext - {r_ng[GRID_W-1], r_ng};
    assign w_xg_ext   = CMP_W'(w_xg);
    assign w_span_ext = $signed(CMP_W'(r_span));
    assign w_cut      = (w_xg_ext >= w_span_ext);
    assign w_none     = w_xg[GRID_W];

    // Offset of the grid position from the segment start; never above the span.
    assign w_gp = r_ng - {r_prev_x[XY_W-1], r_prev_x};

    // The sample is the last of its point when the following grid position lies
    // beyond the point or when the run reaches MAX_RUN samples.
    assign w_ng_step = {r_ng[GRID_W-1], r_ng} + (GRID_W + 1)'(w_step);
    assign w_past_x  = (w_ng_step > w_x_ext);

    // One step of the divider. It keeps prefix * num = Q * dvs + R with R < dvs,
    // where prefix is the part of the dividend shifted in so far. Doubling and
    // adding num leave 2R + num below three divisors, so the quotient digit is
    // 0, 1 or 2; it is kept as two bit rows that are summed once at the end.
    assign w_div_bit  = r_sh[XY_W-1];
    assign w_s        = (SUB_W'(r_rem) << 1) + (w_div_bit ? SUB_W'(r_num) : '0);
    assign w_d1       = w_s - SUB_W'(r_dvs);
    assign w_d2       = w_s - (SUB_W'(r_dvs) << 1);
    assign w_ge1      = !w_d1[SUB_W-1];
    assign w_ge2      = !w_d2[SUB_W-1];
    assign w_rem_next = w_ge2 ? w_d2 : (w_ge1 ? w_d1 : w_s);

    // Interpolated value, saturated to the 32-bit range.
    assign w_py_ext = {{2{r_prev_y[XY_W-1]}}, r_prev_y};
    assign w_q_ext  = $signed({1'b0, r_q});
    assign w_v      = r_neg ? (w_py_ext - w_q_ext) : (w_py_ext + w_q_ext);
    assign w_ovf    = (w_v[XY_W+1:XY_W-1] != '0) && (w_v[XY_W+1:XY_W-1] != '1);
    assign w_sat    = w_ovf ? {w_v[XY_W+1], {(XY_W-1){!w_v[XY_W+1]}}} : w_v[XY_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!r_have_first) begin
                    n_state = S_PUT;
                end else if (w_dx[XY_W] || (w_dx == '0) || w_none) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_bit == DCW'(XY_W - 1)) begin
                    n_state = r_skip ? S_SKIPFIN : S_SUM;
                end
            end
            S_SUM: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                n_state = S_PUT;
            end
            S_PUT: begin
                if (w_out_free) begin
                    if (r_first) begin
                        n_state = S_IDLE;
                    end else if (r_last) begin
                        n_state = r_cut ? S_SKIPLD : S_IDLE;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_SKIPLD: begin
                n_state = S_DIV;
            end
            S_SKIPFIN: begin
                n_state = S_SKIPADD;
            end
            S_SKIPADD: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, segment state and the configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_have_first <= 1'b0;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_ng         <= '0;
            r_grid_step  <= ugl_pkg::GRID_STEP_RESET;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                r_grid_step <= i_cfg_data;
            end

            if (o_sample.ready) begin
                r_out_valid <= 1'b0;
            end
            if ((r_state == S_PUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end

            unique case (r_state)
                S_CHECK: begin
                    if (!r_have_first) begin
                        // First point of a sequence: it starts the grid.
                        r_prev_x     <= r_x;
                        r_prev_y     <= r_y;
                        r_ng         <= {r_x[XY_W-1], r_x} + GRID_W'(w_step);
                        r_have_first <= !r_end;
                    end else if (w_dx == '0) begin
                        // Same x again: only the segment start value moves.
                        r_prev_y     <= r_y;
                        r_have_first <= !r_end;
                    end else if (w_dx[XY_W]) begin
                        r_have_first <= !r_end;
                    end else if (w_none) begin
                        r_prev_x     <= r_x;
                        r_prev_y     <= r_y;
                        r_have_first <= !r_end;
                    end
                end
                S_PUT: begin
                    if (w_out_free && !r_first) begin
                        r_ng <= r_ng + GRID_W'(w_step);
                        if (r_last && !r_cut) begin
                            r_prev_x     <= r_x;
                            r_prev_y     <= r_y;
                            r_have_first <= !r_end;
                        end
                    end
                end
                S_SKIPFIN: begin
                    // x minus (x - next) mod step is the last grid position at
                    // or below x; one more step passes beyond it.
                    r_ng <= {r_x[XY_W-1], r_x} - {1'b0, r_rem};
                end
                S_SKIPADD: begin
                    r_ng         <= r_ng + GRID_W'(w_step);
                    r_prev_x     <= r_x;
                    r_prev_y     <= r_y;
                    r_have_first <= !r_end;
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_span <= SPAN_W'(w_step) * SPAN_W'(MAX_RUN);

        if (w_accept) begin
            r_x   <= i_point.point_x;
            r_y   <= i_point.point_y;
            r_end <= i_point.seq_end;
        end

        unique case (r_state)
            S_CHECK: begin
                r_first <= !r_have_first;
                r_cut   <= r_have_first && w_cut;
                r_last  <= 1'b1;
                r_sx    <= r_x;
                r_sy    <= r_y;
                r_neg   <= w_y_below;
                r_a     <= w_y_below ? w_dy_neg[XY_W-1:0] : w_dy_pos[XY_W-1:0];
                r_cnt   <= '0;
            end
            S_LOAD: begin
                r_skip <= 1'b0;
                r_sh   <= r_a;
                r_num  <= w_gp[XY_W-1:0];
                r_dvs  <= w_dx[XY_W-1:0];
                r_rem  <= '0;
                r_qa   <= '0;
                r_qb   <= '0;
                r_bit  <= '0;
            end
            S_SKIPLD: begin
                // The remainder of (x - next) by the step locates the skipped grid.
                r_skip <= 1'b1;
                r_sh   <= w_xg[XY_W-1:0];
                r_num  <= XY_W'(1);
                r_dvs  <= XY_W'(w_step);
                r_rem  <= '0;
                r_qa   <= '0;
                r_qb   <= '0;
                r_bit  <= '0;
            end
            S_DIV: begin
                r_sh  <= {r_sh[XY_W-2:0], 1'b0};
                r_rem <= w_rem_next[XY_W-1:0];
                r_qa  <= {r_qa[XY_W-2:0], w_ge1};
                r_qb  <= {r_qb[XY_W-2:0], w_ge2};
                r_bit <= r_bit + DCW'(1);
            end
            S_SUM: begin
                r_q    <= {1'b0, r_qa} + {1'b0, r_qb};
                r_last <= w_past_x || (r_cnt == CW'(MAX_RUN - 1));
            end
            S_FIN: begin
                r_sx <= r_ng[XY_W-1:0];
                r_sy <= w_sat;
            end
            S_PUT: begin
                if (w_out_free) begin
                    r_o_x    <= r_sx;
                    r_o_y    <= r_sy;
                    r_o_last <= r_last;
                    r_o_cut  <= r_cut;
                    if (!r_first && !r_last) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // The divider never runs with a zero divisor and keeps its remainder reduced.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dvs != '0))
        else $error("divider started with a zero divisor");

    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_dvs))
        else $error("divider remainder not below divisor");

    // Between items the next grid position always lies beyond the segment start.
    a_grid_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && r_have_first) |->
            (r_ng > $signed({r_prev_x[XY_W-1], r_prev_x})))
        else $error("next grid position not beyond the last point");

    // Skipping only follows a cut run.
    a_skip_cut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SKIPLD) |-> (r_cut && !r_first))
        else $error("grid skip without a cut run");

    // A sample handed to the output register shows up as valid.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_PUT) && w_out_free) |=> r_out_valid)
        else $error("sample lost on its way to the output");

endmodule

`default_nettype wire

@@ sim/uniform_grid_linear_resampler_checker.sv @@
module uniform_grid_linear_resampler_checker #(
    parameter int MAX_RUN = ugl_pkg::MAX_RUN_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ugl_pkg::STEP_W-1:0]         i_cfg_data,
    input  logic                               i_point_valid,
    input  logic                               i_point_ready,
    input  logic signed [ugl_pkg::XY_W-1:0]    i_point_x,
    input  logic signed [ugl_pkg::XY_W-1:0]    i_point_y,
    input  logic                               i_seq_end,
    input  logic                               i_sample_valid,
    input  logic                               i_sample_ready,
    input  logic signed [ugl_pkg::XY_W-1:0]    i_sample_x,
    input  logic signed [ugl_pkg::XY_W-1:0]    i_sample_y,
    input  logic                               i_run_last,
    input  logic                               i_run_cut,
    output int                                 o_pending,
    output int                                 o_mismatches
);

    typedef struct packed {
        logic signed [ugl_pkg::XY_W-1:0] sample_x;
        logic signed [ugl_pkg::XY_W-1:0] sample_y;
        logic                            run_last;
        logic                            run_cut;
    } grid_sample_t;

    localparam longint XY_MAX = 2147483647;
    localparam longint XY_MIN = -XY_MAX - 1;

    logic [ugl_pkg::STEP_W-1:0] grid_step;
    longint                     seg_x;
    longint                     seg_y;
    longint                     next_gx;
    logic                       seg_open;
    grid_sample_t               sample_fifo[$];
    int                         mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("mismatch in %s: got %h, expected %h at %0t", what, got, want, $time);
    endtask

    // Value of the segment from (seg_x, seg_y) to (x, y) at gx, quotient truncated
    // toward zero and the sum clamped to 32 bits.
    function automatic logic signed [31:0] lerp_at(input longint gx, input longint x,
                                                    input longint y);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] mag;
        logic [63:0] quot;
        longint      dy;
        longint      val;
        num  = gx - seg_x;
        den  = x - seg_x;
        dy   = y - seg_y;
        mag  = (dy < 0) ? -dy : dy;
        quot = (mag / den) * num + ((mag % den) * num) / den;
        val  = (dy < 0) ? -longint'(quot) : longint'(quot);
        val  = seg_y + val;
        if (val > XY_MAX) val = XY_MAX;
        if (val < XY_MIN) val = XY_MIN;
        return val[31:0];
    endfunction

    task automatic predict_point(input logic signed [31:0] px, input logic signed [31:0] py,
                                 input logic last_point);
        grid_sample_t run_buf[MAX_RUN];
        grid_sample_t s;
        longint       x;
        longint       y;
        longint       stride;
        longint       hops;
        int           n;
        x      = px;
        y      = py;
        stride = (grid_step == '0) ? 1 : longint'(grid_step);
        n      = 0;
        if (!seg_open) begin
            s.sample_x = px;
            s.sample_y = py;
            s.run_last = 1'b1;
            s.run_cut  = 1'b0;
            sample_fifo.insert(sample_fifo.size(), s);
            seg_x    = x;
            seg_y    = y;
            next_gx  = x + stride;
            seg_open = 1'b1;
        end else if (x == seg_x) begin
            seg_y = y;
        end else if (x > seg_x) begin
            while (next_gx <= x && n < MAX_RUN) begin
                run_buf[n].sample_x = next_gx[31:0];
                run_buf[n].sample_y = lerp_at(next_gx, x, y);
                run_buf[n].run_last = 1'b0;
                run_buf[n].run_cut  = 1'b0;
                n++;
                next_gx += stride;
            end
            // Grid positions past the cap are skipped, and the whole run is flagged.
            if (next_gx <= x) begin
                hops = (x - next_gx) / stride + 1;
                next_gx += hops * stride;
                for (int i = 0; i < n; i++) run_buf[i].run_cut = 1'b1;
            end
            if (n > 0) run_buf[n-1].run_last = 1'b1;
            for (int i = 0; i < n; i++) sample_fifo.insert(sample_fifo.size(), run_buf[i]);
            seg_x = x;
            seg_y = y;
        end
        if (last_point) seg_open = 1'b0;
    endtask

    always @(posedge i_clk) begin
        grid_sample_t want;
        if (!i_rst_n) begin
            grid_step = ugl_pkg::GRID_STEP_RESET;
            seg_x     = 0;
            seg_y     = 0;
            next_gx   = 0;
            seg_open  = 1'b0;
            sample_fifo.delete();
        end else begin
            if (i_sample_valid && i_sample_ready) begin
                if (sample_fifo.size() == 0) begin
                    report_mismatch("unexpected sample_x", i_sample_x, '0);
                end else begin
                    want = sample_fifo.pop_front();
                    if (i_sample_x !== want.sample_x)
                        report_mismatch("sample_x", i_sample_x, want.sample_x);
                    if (i_sample_y !== want.sample_y)
                        report_mismatch("sample_y", i_sample_y, want.sample_y);
                    if (i_run_last !== want.run_last)
                        report_mismatch("run_last", 32'(i_run_last), 32'(want.run_last));
                    if (i_run_cut !== want.run_cut)
                        report_mismatch("run_cut", 32'(i_run_cut), 32'(want.run_cut));
                end
            end
            if (i_cfg_we) grid_step = i_cfg_data;
            if (i_point_valid && i_point_ready) predict_point(i_point_x, i_point_y, i_seq_end);
        end
        o_pending <= sample_fifo.size();
    end

endmodule

@@ sim/uniform_grid_linear_resampler_tb.sv @@
module uniform_grid_linear_resampler_tb;

    // Q16.16 limits, held in 64 bits so that the point generator can detect overflow.
    localparam longint XY_MAX = 2147483647;
    localparam longint XY_MIN = -XY_MAX - 1;
    localparam longint STEP_DEFAULT = 13107;

    // Cycles to let pass once every expected sample is in; this covers a point that
    // produces nothing, and the skip-ahead work at the end of a cut run.
    localparam int SETTLE_CYCLES = 150;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [ugl_pkg::STEP_W-1:0] i_cfg_data;

    int     pending_samples;
    int     mismatches;

    // Generator bookkeeping only: where the current polyline stands, and whether a
    // sequence is open. Expected values are worked out inside the checker.
    longint seq_last_x;
    bit     seq_open;
    longint cur_step;
    bit     calm;

    ugl_point_if  point_ch ();
    ugl_sample_if sample_ch ();

    uniform_grid_linear_resampler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_point    (point_ch),
        .o_sample   (sample_ch)
    );

    uniform_grid_linear_resampler_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_point_valid  (point_ch.valid),
        .i_point_ready  (point_ch.ready),
        .i_point_x      (point_ch.point_x),
        .i_point_y      (point_ch.point_y),
        .i_seq_end      (point_ch.seq_end),
        .i_sample_valid (sample_ch.valid),
        .i_sample_ready (sample_ch.ready),
        .i_sample_x     (sample_ch.sample_x),
        .i_sample_y     (sample_ch.sample_y),
        .i_run_last     (sample_ch.run_last),
        .i_run_cut      (sample_ch.run_cut),
        .o_pending      (pending_samples),
        .o_mismatches   (mismatches)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog. The slowest legal run, with every point producing a full cut run
    // and every sample stalled to the maximum, stays far below this bound.
    initial begin
        #120000000;
        $display("FAILURE");
        $finish;
    end

    // Receiver side. Before each sample it holds ready low for a random number of
    // cycles, unless a calm stretch is in progress. Ready is only changed when the
    // gap calls for it, so it never gets two assignments in one step.
    initial begin
        int gap;
        sample_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                sample_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            sample_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!sample_ch.valid) @(posedge i_clk);
        end
    end

    // Drives one point and returns at the edge that accepts it, leaving valid high.
    // The caller either sends the next point right away or drops valid.
    task automatic send_point(input longint px, input longint py, input logic last_point);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            point_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        point_ch.valid   <= 1'b1;
        point_ch.point_x <= px[31:0];
        point_ch.point_y <= py[31:0];
        point_ch.seq_end <= last_point;
        @(posedge i_clk);
        while (!point_ch.ready) @(posedge i_clk);
    endtask

    // Stops the point stream and waits until the block has delivered every expected
    // sample and finished any work that produces none. It first waits for the checker
    // to take in the last accepted point, before its count of pending samples is trusted.
    task automatic settle_block();
        point_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_samples != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_grid_step(input logic [ugl_pkg::STEP_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_step = value;
    endtask

    function automatic longint corner_value();
        case ($urandom_range(0, 3))
            0:       return XY_MIN;
            1:       return XY_MAX;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    // Random polylines. Most points move forward by a few grid steps, so that each one
    // produces a handful of samples; some repeat the last x, some step backward and
    // are ignored, and a few jump far enough to hit the run cap. Points that step
    // backward do not count toward the item budget.
    task automatic run_phase(input int n_items);
        int       counted;
        int       pick;
        longint   k;
        longint   target;
        longint   stride;
        longint   jitter;
        longint   x;
        longint   y;
        logic     last_point;
        bit       ignored;
        counted = 0;
        stride  = (cur_step == 0) ? 1 : cur_step;
        while (counted < n_items) begin
            if (counted % 40 == 0) calm = ($urandom_range(0, 3) == 0);
            ignored    = 1'b0;
            last_point = ($urandom_range(0, 19) == 0);
            y = longint'(signed'($urandom));
            if ($urandom_range(0, 9) == 0) y = corner_value();
            pick = $urandom_range(0, 99);
            if (!seq_open) begin
                x = ($urandom_range(0, 3) == 0) ? corner_value() : longint'(signed'($urandom));
            end else if (pick < 8) begin
                x = seq_last_x;
            end else if (pick < 13 && seq_last_x > XY_MIN) begin
                target = seq_last_x - $urandom_range(1, 1000);
                x = (target < XY_MIN) ? XY_MIN : target;
                ignored = 1'b1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 3)       k = $urandom_range(65, 150);
                else if (pick < 15) k = $urandom_range(3, 12);
                else                k = $urandom_range(0, 2);
                jitter = $urandom_range(0, 32'(stride - 1));
                target = seq_last_x + k * stride + jitter + 1;
                // A polyline that runs into the top of the range ends there.
                if (target >= XY_MAX) begin
                    target     = XY_MAX;
                    last_point = 1'b1;
                end
                x = target;
            end
            send_point(x, y, last_point);
            if (!ignored) begin
                seq_last_x = x;
                counted++;
            end
            seq_open = !last_point;
        end
    endtask

    initial begin
        logic [ugl_pkg::STEP_W-1:0] phase_steps[7];
        longint                     base;

        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_data         <= '0;
        point_ch.valid     <= 1'b0;
        point_ch.point_x   <= '0;
        point_ch.point_y   <= '0;
        point_ch.seq_end   <= 1'b0;
        seq_last_x = 0;
        seq_open   = 1'b0;
        cur_step   = STEP_DEFAULT;
        calm       = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed points at the reset grid step of 0.2.
        // First point at the bottom of the range passes straight through.
        send_point(XY_MIN, XY_MAX, 1'b0);
        // Two grid positions fall in this segment, with the widest possible fall in y.
        send_point(XY_MIN + 2 * STEP_DEFAULT, XY_MIN, 1'b0);
        // Same x again: nothing comes out, but the segment now starts at the new y.
        send_point(XY_MIN + 2 * STEP_DEFAULT, 12345, 1'b0);
        // Stepping backward is ignored.
        send_point(XY_MIN + STEP_DEFAULT, 0, 1'b0);
        // A hundred grid positions in one segment: the run is capped and flagged.
        base = XY_MIN + 102 * STEP_DEFAULT + 7;
        send_point(base, -1, 1'b0);
        // Last point of the sequence.
        send_point(base + STEP_DEFAULT / 2, 32'sh7FFF_0000, 1'b1);
        // A sequence of a single point at the top of the range.
        send_point(XY_MAX, XY_MIN, 1'b1);
        // Grid position lands exactly on x, then a point with no grid position inside.
        send_point(0, 0, 1'b0);
        send_point(STEP_DEFAULT, 65536, 1'b0);
        send_point(STEP_DEFAULT + 1, -65536, 1'b0);
        send_point(5 * STEP_DEFAULT, 32'sh1234_5678, 1'b0);
        // A backward point that ends the sequence is ignored but still rearms it.
        send_point(0, 1, 1'b1);
        // From near zero straight to the top of the range: a long cut run.
        send_point(-100, -5, 1'b0);
        send_point(XY_MAX, XY_MAX, 1'b1);
        // Starting one below the top, then reaching the top with no grid position.
        send_point(XY_MAX - 1, -1, 1'b0);
        send_point(XY_MAX, 0, 1'b1);
        seq_open = 1'b0;
        settle_block();

        // Random polylines under a range of grid steps: the smallest, zero (taken as
        // the smallest), one unit, the largest, two random ones, and back to 0.2.
        phase_steps[0] = ugl_pkg::STEP_W'(1);
        phase_steps[1] = '0;
        phase_steps[2] = ugl_pkg::STEP_W'(65536);
        phase_steps[3] = 31'h7FFF_FFFF;
        phase_steps[4] = ugl_pkg::STEP_W'($urandom_range(2, 200000));
        phase_steps[5] = ugl_pkg::STEP_W'($urandom_range(1, 32'h7FFF_FFFF));
        phase_steps[6] = ugl_pkg::STEP_W'(STEP_DEFAULT);
        foreach (phase_steps[i]) begin
            write_grid_step(phase_steps[i]);
            run_phase(70);
            settle_block();
        end

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/ugl_pkg.sv
src/ugl_point_if.sv
src/ugl_sample_if.sv
src/uniform_grid_linear_resampler.sv
sim/uniform_grid_linear_resampler_checker.sv
sim/uniform_grid_linear_resampler_tb.sv
